/* rtl/spq_pkg.sv */
// Shared types and constants for the two-class sorted priority queue.
`default_nettype none

package spq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned WEIGHT_W = 10;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQUEUE = 2'd0,
    KIND_DEQUEUE = 2'd1,
    KIND_LOOKUP  = 2'd2
  } spq_kind_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } spq_state_e;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [WEIGHT_W-1:0] weight;
  } spq_entry_t;

  // Command broadcast to every cell of one queue.
  typedef struct packed {
    logic       ins;
    logic       pop;
    logic       look;
    spq_entry_t data;
  } spq_cmd_t;

endpackage

`default_nettype wire

/* rtl/two_class_sorted_priority_queue_core.sv */
// Top level of the two-class sorted priority queue: control, two cell chains, result register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------------
//  in      | input     | in_valid_i / in_ready_o   | kind, item_id, priority_class, item_weight
//  out     | output    | out_valid_o / out_ready_i | took_*, found, rejected, both counts
//
// Enqueue, dequeue and the unused kind: every cell compares and shifts in the accept cycle
// and the result register loads at the same edge.
// Lookup: each cell registers its own match bit, then the match bits of both chains
// are ORed into the result register.
// One item is in flight at a time; a new transfer is taken in the cycle the held
// result is drained. Reset empties both queues (fill counts to zero); no clearing pass.
// A stalled output holds its result and blocks further input transfers.
`default_nettype none

module two_class_sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [KIND_W-1:0]   kind_i,
  input  wire logic [ID_W-1:0]     item_id_i,
  input  wire logic                priority_class_i,
  input  wire logic [WEIGHT_W-1:0] item_weight_i,

  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     took_valid_o,
  output logic [ID_W-1:0]          took_id_o,
  output logic                     took_class_o,
  output logic [WEIGHT_W-1:0]      took_weight_o,
  output logic                     found_o,
  output logic                     rejected_o,
  output logic [COUNT_W-1:0]       priority_count_o,
  output logic [COUNT_W-1:0]       normal_count_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  spq_state_e state_q, state_d;

  spq_cmd_t         p_cmd, n_cmd;
  spq_entry_t       p_head, n_head;
  logic [CNT_W-1:0] p_fill, n_fill;
  logic             p_match, n_match;

  logic in_fire;
  logic is_enq, is_deq, is_look;
  logic p_full, n_full;
  logic ins_p, ins_n, pop_p, pop_n;
  logic load_op, load_look;

  logic [CNT_W-1:0] p_next, n_next;

  // Result register; the valid flag resets, the payload does not need to.
  logic                out_valid_q;
  logic                took_valid_q, took_class_q, found_q, rejected_q;
  logic [ID_W-1:0]     took_id_q;
  logic [WEIGHT_W-1:0] took_weight_q;
  logic [COUNT_W-1:0]  p_count_q, n_count_q;

  // Accept when idle and the result register is free or drains now.
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_enq  = (kind_i == KIND_ENQUEUE);
  assign is_deq  = (kind_i == KIND_DEQUEUE);
  assign is_look = (kind_i == KIND_LOOKUP);

  assign p_full = (p_fill == CNT_W'(QUEUE_DEPTH));
  assign n_full = (n_fill == CNT_W'(QUEUE_DEPTH));

  // Enqueue goes to the selected class unless it is full; dequeue favors priority.
  assign ins_p = in_fire && is_enq && priority_class_i && !p_full;
  assign ins_n = in_fire && is_enq && !priority_class_i && !n_full;
  assign pop_p = in_fire && is_deq && (p_fill != '0);
  assign pop_n = in_fire && is_deq && (p_fill == '0) && (n_fill != '0);

  always_comb begin
    p_cmd.ins  = ins_p;
    p_cmd.pop  = pop_p;
    p_cmd.look = in_fire && is_look;
    p_cmd.data = '{id: item_id_i, weight: item_weight_i};
    n_cmd      = p_cmd;
    n_cmd.ins  = ins_n;
    n_cmd.pop  = pop_n;
  end

  spq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_prio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (p_cmd),
    .head_o  (p_head),
    .fill_o  (p_fill),
    .match_o (p_match)
  );

  spq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (n_cmd),
    .head_o  (n_head),
    .fill_o  (n_fill),
    .match_o (n_match)
  );

  // Occupancy after this transfer, as the result reports it.
  always_comb begin
    p_next = p_fill;
    n_next = n_fill;
    if (ins_p) p_next = p_fill + CNT_W'(1);
    if (pop_p) p_next = p_fill - CNT_W'(1);
    if (ins_n) n_next = n_fill + CNT_W'(1);
    if (pop_n) n_next = n_fill - CNT_W'(1);
  end

  // Sequencer: a lookup passes through ST_LOOKUP, where the registered match bits are collected.
  always_comb begin
    state_d    = state_q;
    load_op    = 1'b0;
    load_look  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_look) begin
            state_d = ST_LOOKUP;
          end else begin
            load_op = 1'b1;
          end
        end
      end
      ST_LOOKUP: begin
        load_look = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_op || load_look) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_op) begin
      took_valid_q  <= pop_p || pop_n;
      took_class_q  <= pop_p;
      took_id_q     <= pop_p ? p_head.id : (pop_n ? n_head.id : '0);
      took_weight_q <= pop_p ? p_head.weight : (pop_n ? n_head.weight : '0);
      found_q       <= 1'b0;
      rejected_q    <= is_enq && (priority_class_i ? p_full : n_full);
      p_count_q     <= COUNT_W'(p_next);
      n_count_q     <= COUNT_W'(n_next);
    end else if (load_look) begin
      took_valid_q  <= 1'b0;
      took_class_q  <= 1'b0;
      took_id_q     <= '0;
      took_weight_q <= '0;
      found_q       <= p_match || n_match;
      rejected_q    <= 1'b0;
      p_count_q     <= COUNT_W'(p_fill);
      n_count_q     <= COUNT_W'(n_fill);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign took_valid_o     = took_valid_q;
  assign took_id_o        = took_id_q;
  assign took_class_o     = took_class_q;
  assign took_weight_o    = took_weight_q;
  assign found_o          = found_q;
  assign rejected_o       = rejected_q;
  assign priority_count_o = p_count_q;
  assign normal_count_o   = n_count_q;

endmodule

`default_nettype wire

/* rtl/spq_cell.sv */
// One slot of a sorted queue: holds an entry and shifts with its neighbors.
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire spq_cmd_t   cmd_i,
  input  wire logic       occ_i,
  input  wire logic       prev_lt_i,
  input  wire spq_entry_t left_i,
  input  wire spq_entry_t right_i,
  output spq_entry_t      entry_o,
  output logic            lt_o,
  output logic            match_o
);

  spq_entry_t entry_q, entry_d;
  logic       match_q, match_d;

  // Occupied slot whose id sorts strictly ahead of the new one.
  assign lt_o = occ_i && (entry_q.id < cmd_i.data.id);

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    if (cmd_i.ins) begin
      if (!lt_o) begin
        entry_d = prev_lt_i ? cmd_i.data : left_i;
      end
    end else if (cmd_i.pop) begin
      entry_d = right_i;
    end
    if (cmd_i.look) begin
      match_d = occ_i && (entry_q.id == cmd_i.data.id);
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

/* rtl/spq_queue.sv */
// Sorted queue built as a chain of cells plus its fill count.
`default_nettype none

module spq_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire spq_cmd_t         cmd_i,
  output spq_entry_t            head_o,
  output logic [CNT_W-1:0]      fill_o,
  output logic                  match_o
);

  logic [CNT_W-1:0] fill_q, fill_d;

  spq_entry_t             entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] lt;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] occ;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic       prev_lt;
    spq_entry_t left, right;

    assign occ[g] = fill_q > CNT_W'(g);

    if (g == 0) begin : g_first
      assign prev_lt = 1'b1;
      assign left    = cmd_i.data;
    end else begin : g_inner
      assign prev_lt = lt[g-1];
      assign left    = entry[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right = entry[g];
    end else begin : g_mid
      assign right = entry[g+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd_i),
      .occ_i     (occ[g]),
      .prev_lt_i (prev_lt),
      .left_i    (left),
      .right_i   (right),
      .entry_o   (entry[g]),
      .lt_o      (lt[g]),
      .match_o   (match[g])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.ins) begin
      fill_d = fill_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      fill_d = fill_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign head_o  = entry[0];
  assign fill_o  = fill_q;
  assign match_o = |match;

endmodule

`default_nettype wire

/* rtl/spq_checker.sv */
// Port-level checker for the two-class sorted priority queue, bound to the top level.
`default_nettype none

module spq_checker
  import spq_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic                took_valid_o,
  input wire logic [ID_W-1:0]     took_id_o,
  input wire logic                took_class_o,
  input wire logic [WEIGHT_W-1:0] took_weight_o,
  input wire logic                found_o,
  input wire logic                rejected_o,
  input wire logic [COUNT_W-1:0]  priority_count_o,
  input wire logic [COUNT_W-1:0]  normal_count_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(took_id_o) && $stable(found_o)
      && $stable(priority_count_o) && $stable(normal_count_o))
    else $error("stalled result changed");

  // At most one of the per-kind flags is set.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({took_valid_o, found_o, rejected_o}))
    else $error("more than one kind flag set");

  // Took fields read zero unless an entry was returned.
  a_took_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !took_valid_o |-> took_id_o == '0 && took_weight_o == '0
      && !took_class_o)
    else $error("took fields not cleared");

  // A normal entry is dequeued only when the priority queue is empty.
  a_normal_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && took_valid_o && !took_class_o |-> priority_count_o == '0)
    else $error("normal entry taken while priority queue held entries");

endmodule

bind two_class_sorted_priority_queue_core spq_checker u_chk (.*);

`default_nettype wire

/* sim/spq_checker.sv */
// Scoreboard for the two-class sorted priority queue: predicts every result and compares it.
`default_nettype none

module spq_scoreboard
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire logic [KIND_W-1:0]   kind_i,
  input  wire logic [ID_W-1:0]     item_id_i,
  input  wire logic                priority_class_i,
  input  wire logic [WEIGHT_W-1:0] item_weight_i,

  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire logic                took_valid_i,
  input  wire logic [ID_W-1:0]     took_id_i,
  input  wire logic                took_class_i,
  input  wire logic [WEIGHT_W-1:0] took_weight_i,
  input  wire logic                found_i,
  input  wire logic                rejected_i,
  input  wire logic [COUNT_W-1:0]  priority_count_i,
  input  wire logic [COUNT_W-1:0]  normal_count_i,

  output int unsigned              mismatch_count_o,
  output int unsigned              pending_o
);

  localparam int unsigned CLASS_NORMAL   = 0;
  localparam int unsigned CLASS_PRIORITY = 1;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct packed {
    logic                took_valid;
    logic [ID_W-1:0]     took_id;
    logic                took_class;
    logic [WEIGHT_W-1:0] took_weight;
    logic                found;
    logic                rejected;
    logic [COUNT_W-1:0]  priority_count;
    logic [COUNT_W-1:0]  normal_count;
  } queue_result_t;

  // Shadow of both sorted queues, indexed by class.
  spq_entry_t    held [2][QUEUE_DEPTH];
  int unsigned   fill [2];
  queue_result_t expected_results [$];

  // Apply one operation to the shadow queues and return the result it produces.
  function automatic queue_result_t step_queues(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                                logic cls, logic [WEIGHT_W-1:0] weight);
    queue_result_t res;
    int unsigned   pos;
    int unsigned   i;
    int unsigned   c;
    res = '0;
    c = cls ? CLASS_PRIORITY : CLASS_NORMAL;
    case (kind)
      KIND_ENQUEUE: begin
        if (fill[c] >= QUEUE_DEPTH) begin
          res.rejected = 1'b1;
        end else begin
          // equal ids: new entry lands in front of them
          pos = 0;
          while (pos < fill[c] && held[c][pos].id < id) pos++;
          for (i = fill[c]; i > pos; i--) held[c][i] = held[c][i-1];
          held[c][pos].id     = id;
          held[c][pos].weight = weight;
          fill[c]++;
        end
      end
      KIND_DEQUEUE: begin
        if (fill[CLASS_PRIORITY] > 0 || fill[CLASS_NORMAL] > 0) begin
          c = (fill[CLASS_PRIORITY] > 0) ? CLASS_PRIORITY : CLASS_NORMAL;
          res.took_valid  = 1'b1;
          res.took_class  = (c == CLASS_PRIORITY);
          res.took_id     = held[c][0].id;
          res.took_weight = held[c][0].weight;
          for (i = 1; i < fill[c]; i++) held[c][i-1] = held[c][i];
          fill[c]--;
        end
      end
      KIND_LOOKUP: begin
        for (c = 0; c < 2; c++)
          for (i = 0; i < fill[c]; i++)
            if (held[c][i].id == id) res.found = 1'b1;
      end
      default: ;
    endcase
    res.priority_count = COUNT_W'(fill[CLASS_PRIORITY]);
    res.normal_count   = COUNT_W'(fill[CLASS_NORMAL]);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t seen;
    queue_result_t want;
    if (!rst_ni) begin
      fill[CLASS_NORMAL]   = 0;
      fill[CLASS_PRIORITY] = 0;
      expected_results.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = '{took_valid_i, took_id_i, took_class_i, took_weight_i,
                 found_i, rejected_i, priority_count_i, normal_count_i};
        if (expected_results.size() == 0) begin
          if (mismatch_count_o < REPORT_LIMIT)
            $display("%0t: result with nothing pending: took=%0b id=%h cls=%0b w=%h",
                     $realtime, seen.took_valid, seen.took_id, seen.took_class,
                     seen.took_weight);
          mismatch_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            if (mismatch_count_o < REPORT_LIMIT) begin
              $display("%0t: result mismatch (took,id,cls,weight,found,rej,pcnt,ncnt)",
                       $realtime);
              $display("  expected %0b %h %0b %h %0b %0b %0d %0d", want.took_valid,
                       want.took_id, want.took_class, want.took_weight, want.found,
                       want.rejected, want.priority_count, want.normal_count);
              $display("  actual   %0b %h %0b %h %0b %0b %0d %0d", seen.took_valid,
                       seen.took_id, seen.took_class, seen.took_weight, seen.found,
                       seen.rejected, seen.priority_count, seen.normal_count);
            end
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(step_queues(kind_i, item_id_i, priority_class_i,
                                               item_weight_i));
      pending_o = expected_results.size();
    end
  end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Testbench top for the two-class sorted priority queue: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top;
  import spq_pkg::*;

  localparam int unsigned            CYCLE_LIMIT      = 100000;
  localparam int unsigned            RANDOM_PER_PHASE = 510;
  localparam int unsigned            BURST_LEN        = 32;
  localparam logic [KIND_W-1:0]      KIND_SPARE       = 2'd3;
  localparam int unsigned            MODE_FILL        = 0;
  localparam int unsigned            MODE_DRAIN       = 1;
  localparam int unsigned            MODE_MIXED       = 2;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [KIND_W-1:0]   kind_i;
  logic [ID_W-1:0]     item_id_i;
  logic                priority_class_i;
  logic [WEIGHT_W-1:0] item_weight_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                took_valid_o;
  logic [ID_W-1:0]     took_id_o;
  logic                took_class_o;
  logic [WEIGHT_W-1:0] took_weight_o;
  logic                found_o;
  logic                rejected_o;
  logic [COUNT_W-1:0]  priority_count_o;
  logic [COUNT_W-1:0]  normal_count_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count = 0;
  // Idle odds in percent: sender gap and receiver stall.
  int unsigned gap_pct     = 19;
  int unsigned stall_pct   = 48;

  two_class_sorted_priority_queue_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .item_id_i        (item_id_i),
    .priority_class_i (priority_class_i),
    .item_weight_i    (item_weight_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .took_valid_o     (took_valid_o),
    .took_id_o        (took_id_o),
    .took_class_o     (took_class_o),
    .took_weight_o    (took_weight_o),
    .found_o          (found_o),
    .rejected_o       (rejected_o),
    .priority_count_o (priority_count_o),
    .normal_count_o   (normal_count_o)
  );

  spq_scoreboard u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .kind_i           (kind_i),
    .item_id_i        (item_id_i),
    .priority_class_i (priority_class_i),
    .item_weight_i    (item_weight_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .took_valid_i     (took_valid_o),
    .took_id_i        (took_id_o),
    .took_class_i     (took_class_o),
    .took_weight_i    (took_weight_o),
    .found_i          (found_o),
    .rejected_i       (rejected_o),
    .priority_count_i (priority_count_o),
    .normal_count_i   (normal_count_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #5 clk_i = ~clk_i;

  // Stall the receiver at random; change ready only on the falling edge.
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  // Watchdog: abort a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one item and hold it until the transfer. Enter and leave on a falling edge.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                           input logic cls, input logic [WEIGHT_W-1:0] weight);
    // insert a random gap before the item
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= kind;
    item_id_i        <= id;
    priority_class_i <= cls;
    item_weight_i    <= weight;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Pick an id: mostly a small pool so lookups hit and equal ids collide,
  // sometimes the top of the range, sometimes anything.
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return ID_W'($urandom_range(15));
    if (roll < 65) return ID_W'(16'hFFFF - $urandom_range(3));
    return ID_W'($urandom_range(16'hFFFF));
  endfunction

  initial begin
    int unsigned         phase;
    int unsigned         sent;
    int unsigned         mode;
    int unsigned         enq_pct;
    int unsigned         deq_pct;
    int unsigned         prio_pct;
    int unsigned         roll;
    int unsigned         i;
    logic [KIND_W-1:0]   kind;
    logic [WEIGHT_W-1:0] weight;

    // Drive every input to a known value before the first edge.
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    kind_i           = KIND_ENQUEUE;
    item_id_i        = '0;
    priority_class_i = 1'b0;
    item_weight_i    = '0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty queues, the unused kind, fill the priority queue past full.
    send_item(KIND_DEQUEUE, 16'h0000, 1'b0, 10'h000);
    send_item(KIND_LOOKUP, 16'h0000, 1'b1, 10'h3FF);
    send_item(KIND_SPARE, 16'hFFFF, 1'b1, 10'h3FF);
    for (i = 0; i < 17; i++) begin
      // extremes first, then pairs of equal ids with distinct weights
      send_item(KIND_ENQUEUE,
                (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : ID_W'(1 << ((i - 2) / 2)),
                1'b1, i[0] ? 10'h3FF : WEIGHT_W'(i));
    end
    send_item(KIND_LOOKUP, 16'hFFFF, 1'b0, 10'h000);
    send_item(KIND_DEQUEUE, 16'h0000, 1'b0, 10'h000);
    send_item(KIND_ENQUEUE, 16'h0000, 1'b0, 10'h3FF);
    send_item(KIND_LOOKUP, 16'h1234, 1'b0, 10'h000);

    // Random: three idle profiles, each as bursts that fill, drain or mix.
    mode     = MODE_MIXED;
    enq_pct  = 40;
    deq_pct  = 38;
    prio_pct = 50;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin gap_pct = 19; stall_pct = 48; end
        1:       begin gap_pct = 48; stall_pct = 19; end
        default: begin gap_pct = 0;  stall_pct = 0;  end
      endcase
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        if (sent % BURST_LEN == 0) begin
          mode = $urandom_range(2);
          case (mode)
            MODE_FILL:  begin enq_pct = 65; deq_pct = 15; end
            MODE_DRAIN: begin enq_pct = 15; deq_pct = 65; end
            default:    begin enq_pct = 40; deq_pct = 38; end
          endcase
          // lean the burst toward one class or neither, so each queue can empty and fill alone
          case ($urandom_range(2))
            0:       prio_pct = 10;
            1:       prio_pct = 50;
            default: prio_pct = 90;
          endcase
        end
        roll = $urandom_range(99);
        if (roll < 3)                          kind = KIND_SPARE;
        else if (roll < 3 + enq_pct)           kind = KIND_ENQUEUE;
        else if (roll < 3 + enq_pct + deq_pct) kind = KIND_DEQUEUE;
        else                                   kind = KIND_LOOKUP;
        if ($urandom_range(9) == 0) weight = $urandom_range(1) ? '1 : '0;
        else                        weight = WEIGHT_W'($urandom_range(1023));
        send_item(kind, pick_id(), ($urandom_range(99) < prio_pct), weight);
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every pending result, then a short tail for strays.
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (mismatches == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_queue.sv
rtl/two_class_sorted_priority_queue_core.sv
rtl/spq_checker.sv
sim/spq_checker.sv
sim/tb_top.sv
